[src/rci_pkg.sv]
// shared widths, types and register codes for the ray/cylinder intersection block
`timescale 1ns / 1ps
package rci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIR_FRAC  = 30;
  localparam int A_W       = 34;
  localparam int H_W       = 37;
  localparam int C_W       = 51;
  localparam int DISC_W    = 86;
  localparam int ROOT_W    = 43;
  localparam int N_W       = 44;
  localparam int T_W       = 31;
  localparam int REM_W     = 66;
  localparam int IDX_W     = 6;

  localparam logic [A_W-1:0] A_MIN = A_W'(11);
  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5,
    REG_RADIUS   = 3'd6
  } cfg_reg_t;

  // data that rides alongside the root and quotient cells
  typedef struct packed {
    logic [2:0][COORD_W-1:0] o;
    logic [2:0][COORD_W-1:0] d;
    logic [A_W-1:0]          a;
    logic [H_W-1:0]          h;
    logic                    miss;
    logic                    sat;
  } rci_side_t;

  typedef struct packed {
    logic                    valid;
    logic                    en;
  } rci_ctl_t;

  typedef struct packed {
    logic                    hit;
    logic [T_W-1:0]          distance;
    logic [2:0][COORD_W-1:0] point;
  } rci_res_t;

endpackage

[src/rci_ray_if.sv]
// ray item channel
`timescale 1ns / 1ps
interface rci_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

[src/rci_hit_if.sv]
// intersection result channel
`timescale 1ns / 1ps
interface rci_hit_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic        [30:0] distance;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, hit, distance, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, distance, point_x, point_y, point_z, output ready);
endinterface

[src/rci_cfg_if.sv]
// configuration write channel
`timescale 1ns / 1ps
interface rci_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/rci_sqrt_cell.sv]
// one restoring square root cell: decides one root bit per item
`timescale 1ns / 1ps
module rci_sqrt_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rci_pkg::rci_ctl_t          ctl_i,
  input  logic [rci_pkg::IDX_W-1:0]  bit_idx,
  input  rci_pkg::rci_side_t         side_i,
  input  logic [rci_pkg::DISC_W-1:0] rem_i,
  input  logic [rci_pkg::ROOT_W-1:0] root_i,
  output logic                       valid_o,
  output rci_pkg::rci_side_t         side_o,
  output logic [rci_pkg::DISC_W-1:0] rem_o,
  output logic [rci_pkg::ROOT_W-1:0] root_o
);
  import rci_pkg::*;

  logic [DISC_W:0] trial;
  logic            take;

  // trial = 2 * root * 2^k + 4^k
  always_comb begin
    trial = ((DISC_W+1)'(root_i) << ({1'b0, bit_idx} + 7'd1))
          | ((DISC_W+1)'(1) << {bit_idx, 1'b0});
    take  = {1'b0, rem_i} >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (ctl_i.en) begin
      valid_o <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      side_o <= side_i;
      rem_o  <= take ? DISC_W'({1'b0, rem_i} - trial) : rem_i;
      root_o <= take ? (root_i | (ROOT_W'(1) << bit_idx)) : root_i;
    end
  end

endmodule

[src/rci_div_cell.sv]
// one restoring divider cell: decides one quotient bit per item
`timescale 1ns / 1ps
module rci_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rci_pkg::rci_ctl_t         ctl_i,
  input  logic [rci_pkg::IDX_W-1:0] bit_idx,
  input  rci_pkg::rci_side_t        side_i,
  input  logic [rci_pkg::REM_W-1:0] rem_i,
  input  logic [rci_pkg::T_W-1:0]   q_i,
  output logic                      valid_o,
  output rci_pkg::rci_side_t        side_o,
  output logic [rci_pkg::REM_W-1:0] rem_o,
  output logic [rci_pkg::T_W-1:0]   q_o
);
  import rci_pkg::*;

  logic [REM_W-1:0] dv;
  logic             take;

  always_comb begin
    dv   = REM_W'(side_i.a) << bit_idx;
    take = rem_i >= dv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (ctl_i.en) begin
      valid_o <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      side_o <= side_i;
      rem_o  <= take ? rem_i - dv : rem_i;
      q_o    <= take ? (q_i | (T_W'(1) << bit_idx)) : q_i;
    end
  end

`ifndef SYNTHESIS
  // partial remainder stays below the divisor shifted to the next higher weight
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.valid && !side_i.miss && !side_i.sat) |->
      ((REM_W+1)'(rem_i) < ((REM_W+1)'(side_i.a) << ({1'b0, bit_idx} + 7'd1))))
    else $error("divider remainder out of range");
`endif

endmodule

[src/ray_cylinder_intersect.sv]
// ray against infinite cylinder intersection, fully pipelined
`timescale 1ns / 1ps
// Takes one ray per clock while the output side is not stalled and returns one result item
// per ray, in order. The chain of cells: nine arithmetic stages (axial projection, quadratic
// coefficients, discriminant), 43 square root cells (one root bit each), one stage choosing
// the forward root, 31 divider cells (one bit of t each), two stages for the hit point and
// the output register. A miss (degenerate direction, negative discriminant, both roots
// behind) gives hit, distance and point all zero. Distance and point saturate. The config
// port is always ready; write it only while no ray is in flight.
module ray_cylinder_intersect (
  input  logic       clk,
  input  logic       rst_n,
  rci_ray_if.sink    in_ch,
  rci_hit_if.source  out_ch,
  rci_cfg_if.sink    cfg_ch
);
  import rci_pkg::*;

  // configuration registers
  logic signed [31:0] ce_r [3];
  logic signed [31:0] ax_r [3];
  logic        [30:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ce_r[0] <= '0; ce_r[1] <= '0; ce_r[2] <= '0;
      ax_r[0] <= '0; ax_r[1] <= '0; ax_r[2] <= 32'sh4000_0000;
      rad_r   <= 31'h0001_0000;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CENTER_X: ce_r[0] <= cfg_ch.data;
        REG_CENTER_Y: ce_r[1] <= cfg_ch.data;
        REG_CENTER_Z: ce_r[2] <= cfg_ch.data;
        REG_AXIS_X:   ax_r[0] <= cfg_ch.data;
        REG_AXIS_Y:   ax_r[1] <= cfg_ch.data;
        REG_AXIS_Z:   ax_r[2] <= cfg_ch.data;
        REG_RADIUS:   rad_r   <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // whole chain advances together; only a full skid stage stops it
  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  logic signed [31:0] in_o [3];
  logic signed [31:0] in_d [3];
  always_comb begin
    in_o[0] = in_ch.origin_x; in_o[1] = in_ch.origin_y; in_o[2] = in_ch.origin_z;
    in_d[0] = in_ch.dir_x;    in_d[1] = in_ch.dir_y;    in_d[2] = in_ch.dir_z;
  end

  // stage 1: offset from axis point, dot products with the axis
  logic signed [32:0] w1 [3];
  logic signed [63:0] pd_f [3];
  logic signed [64:0] pw_f [3];
  logic               s1_v_r;
  logic signed [31:0] s1_o_r [3], s1_d_r [3];
  logic signed [32:0] s1_w_r [3];
  logic signed [33:0] s1_pd_r [3];
  logic signed [34:0] s1_pw_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w1[i]   = 33'(in_o[i]) - 33'(ce_r[i]);
      pd_f[i] = in_d[i] * ax_r[i];
      pw_f[i] = w1[i] * 65'(ax_r[i]);
    end
  end

  // stage 2: clamp the axial components
  logic signed [35:0] sd2;
  logic signed [36:0] sw2;
  logic               s2_v_r;
  logic signed [31:0] s2_o_r [3], s2_d_r [3];
  logic signed [32:0] s2_w_r [3];
  logic signed [32:0] s2_da_r, s2_wa_r;
  logic signed [32:0] da2, wa2;
  localparam logic signed [35:0] LIM_DA = 36'sh0_FFFF_FFFF;
  localparam logic signed [36:0] LIM_WA = 37'sh0_FFFF_FFFF;

  always_comb begin
    sd2 = 36'(s1_pd_r[0]) + 36'(s1_pd_r[1]) + 36'(s1_pd_r[2]);
    sw2 = 37'(s1_pw_r[0]) + 37'(s1_pw_r[1]) + 37'(s1_pw_r[2]);
    da2 = (sd2 > LIM_DA) ? 33'(LIM_DA) : ((sd2 < -LIM_DA) ? 33'(-LIM_DA) : 33'(sd2));
    wa2 = (sw2 > LIM_WA) ? 33'(LIM_WA) : ((sw2 < -LIM_WA) ? 33'(-LIM_WA) : 33'(sw2));
  end

  // stage 3: axial parts projected back onto each coordinate
  logic signed [64:0] qd_f [3], qw_f [3];
  logic               s3_v_r;
  logic signed [31:0] s3_o_r [3], s3_d_r [3];
  logic signed [32:0] s3_w_r [3];
  logic signed [34:0] s3_qd_r [3], s3_qw_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qd_f[i] = s2_da_r * 65'(ax_r[i]);
      qw_f[i] = s2_wa_r * 65'(ax_r[i]);
    end
  end

  // stage 4: perpendicular direction and offset
  logic signed [35:0] dpx [3], wpx [3];
  logic signed [31:0] dp4 [3];
  logic signed [32:0] wp4 [3];
  logic               s4_v_r;
  logic signed [31:0] s4_o_r [3], s4_d_r [3];
  logic signed [31:0] s4_dp_r [3];
  logic signed [32:0] s4_wp_r [3];
  localparam logic signed [35:0] LIM_DP = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] LIM_WP = 36'sh0_FFFF_FFFF;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dpx[i] = 36'(s3_d_r[i]) - 36'(s3_qd_r[i]);
      wpx[i] = 36'(s3_w_r[i]) - 36'(s3_qw_r[i]);
      dp4[i] = (dpx[i] > LIM_DP) ? 32'(LIM_DP)
             : ((dpx[i] < -LIM_DP) ? 32'(-LIM_DP) : 32'(dpx[i]));
      wp4[i] = (wpx[i] > LIM_WP) ? 33'(LIM_WP)
             : ((wpx[i] < -LIM_WP) ? 33'(-LIM_WP) : 33'(wpx[i]));
    end
  end

  // stage 5: per-axis products of the quadratic coefficients
  logic signed [63:0] sq_f [3];
  logic signed [64:0] hp_f [3];
  logic signed [32:0] wn5 [3];
  logic        [31:0] wm5 [3];
  logic        [63:0] ws_f [3];
  logic        [61:0] rr_f;
  logic               s5_v_r;
  logic signed [31:0] s5_o_r [3], s5_d_r [3];
  logic        [31:0] s5_sq_r [3];
  logic signed [34:0] s5_hp_r [3];
  logic        [47:0] s5_ws_r [3];
  logic        [45:0] s5_rr_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_f[i] = s4_dp_r[i] * s4_dp_r[i];
      hp_f[i] = 65'(s4_dp_r[i]) * s4_wp_r[i];
      wn5[i]  = -s4_wp_r[i];
      wm5[i]  = s4_wp_r[i][32] ? wn5[i][31:0] : s4_wp_r[i][31:0];
      ws_f[i] = 64'(wm5[i]) * 64'(wm5[i]);
    end
    rr_f = 62'(rad_r) * 62'(rad_r);
  end

  // stage 6: A, h and C
  logic        [49:0] wsum6;
  logic               s6_v_r;
  logic signed [31:0] s6_o_r [3], s6_d_r [3];
  logic        [A_W-1:0] s6_a_r;
  logic signed [H_W-1:0] s6_h_r;
  logic signed [C_W-1:0] s6_c_r;

  always_comb begin
    wsum6 = 50'(s5_ws_r[0]) + 50'(s5_ws_r[1]) + 50'(s5_ws_r[2]);
  end

  // stage 7: magnitudes split into partial products
  logic signed [H_W-1:0] hn7;
  logic signed [C_W-1:0] cn7;
  logic        [35:0]    mh7;
  logic        [49:0]    mc7;
  logic               s7_v_r;
  logic signed [31:0] s7_o_r [3], s7_d_r [3];
  logic        [A_W-1:0] s7_a_r;
  logic signed [H_W-1:0] s7_h_r;
  logic               s7_miss_r, s7_cpos_r;
  logic        [35:0] s7_ll_r, s7_lh_r, s7_hh_r;
  logic        [58:0] s7_alo_r, s7_ahi_r;

  always_comb begin
    hn7 = -s6_h_r;
    cn7 = -s6_c_r;
    mh7 = s6_h_r[H_W-1] ? hn7[35:0] : s6_h_r[35:0];
    mc7 = s6_c_r[C_W-1] ? cn7[49:0] : s6_c_r[49:0];
  end

  // stage 8: h^2 and A*|C| at the discriminant scale
  logic               s8_v_r;
  logic signed [31:0] s8_o_r [3], s8_d_r [3];
  logic        [A_W-1:0] s8_a_r;
  logic signed [H_W-1:0] s8_h_r;
  logic               s8_miss_r, s8_cpos_r;
  logic        [DISC_W-1:0] s8_hsq_r, s8_ac_r;

  // stage 9: discriminant, head of the root chain
  logic        [DISC_W-1:0] disc9;
  logic                     neg9;
  logic                     s9_v_r;
  rci_side_t                s9_side_r;
  logic        [DISC_W-1:0] s9_disc_r;

  always_comb begin
    neg9  = s8_cpos_r && (s8_ac_r > s8_hsq_r);
    disc9 = s8_cpos_r ? (s8_hsq_r - s8_ac_r) : (s8_hsq_r + s8_ac_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s5_v_r <= 1'b0; s6_v_r <= 1'b0; s7_v_r <= 1'b0; s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid; s2_v_r <= s1_v_r; s3_v_r <= s2_v_r; s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r; s6_v_r <= s5_v_r; s7_v_r <= s6_v_r; s8_v_r <= s7_v_r;
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_o_r[i]  <= in_o[i];
        s1_d_r[i]  <= in_d[i];
        s1_w_r[i]  <= w1[i];
        s1_pd_r[i] <= pd_f[i][63:30];
        s1_pw_r[i] <= pw_f[i][64:30];
        s2_o_r[i]  <= s1_o_r[i]; s2_d_r[i] <= s1_d_r[i]; s2_w_r[i] <= s1_w_r[i];
        s3_o_r[i]  <= s2_o_r[i]; s3_d_r[i] <= s2_d_r[i]; s3_w_r[i] <= s2_w_r[i];
        s3_qd_r[i] <= qd_f[i][64:30];
        s3_qw_r[i] <= qw_f[i][64:30];
        s4_o_r[i]  <= s3_o_r[i]; s4_d_r[i] <= s3_d_r[i];
        s4_dp_r[i] <= dp4[i];
        s4_wp_r[i] <= wp4[i];
        s5_o_r[i]  <= s4_o_r[i]; s5_d_r[i] <= s4_d_r[i];
        s5_sq_r[i] <= sq_f[i][61:30];
        s5_hp_r[i] <= hp_f[i][64:30];
        s5_ws_r[i] <= ws_f[i][63:16];
        s6_o_r[i]  <= s5_o_r[i]; s6_d_r[i] <= s5_d_r[i];
        s7_o_r[i]  <= s6_o_r[i]; s7_d_r[i] <= s6_d_r[i];
        s8_o_r[i]  <= s7_o_r[i]; s8_d_r[i] <= s7_d_r[i];
        s9_side_r.o[i] <= s8_o_r[i];
        s9_side_r.d[i] <= s8_d_r[i];
      end
      s2_da_r <= da2;
      s2_wa_r <= wa2;
      s5_rr_r <= rr_f[61:16];
      s6_a_r  <= A_W'(s5_sq_r[0]) + A_W'(s5_sq_r[1]) + A_W'(s5_sq_r[2]);
      s6_h_r  <= H_W'(s5_hp_r[0]) + H_W'(s5_hp_r[1]) + H_W'(s5_hp_r[2]);
      s6_c_r  <= $signed({1'b0, wsum6}) - $signed(C_W'(s5_rr_r));
      // degenerate perpendicular direction
      s7_miss_r <= s6_a_r < A_MIN;
      s7_cpos_r <= !s6_c_r[C_W-1] && (s6_c_r != '0);
      s7_a_r    <= s6_a_r;
      s7_h_r    <= s6_h_r;
      s7_ll_r   <= 36'(mh7[17:0]) * 36'(mh7[17:0]);
      s7_lh_r   <= 36'(mh7[17:0]) * 36'(mh7[35:18]);
      s7_hh_r   <= 36'(mh7[35:18]) * 36'(mh7[35:18]);
      s7_alo_r  <= 59'(s6_a_r) * 59'(mc7[24:0]);
      s7_ahi_r  <= 59'(s6_a_r) * 59'(mc7[49:25]);
      s8_miss_r <= s7_miss_r;
      s8_cpos_r <= s7_cpos_r;
      s8_a_r    <= s7_a_r;
      s8_h_r    <= s7_h_r;
      s8_hsq_r  <= (DISC_W'(s7_hh_r) << 50) + (DISC_W'(s7_lh_r) << 33)
                 + (DISC_W'(s7_ll_r) << 14);
      s8_ac_r   <= (DISC_W'(s7_ahi_r) << 25) + DISC_W'(s7_alo_r);
      s9_side_r.a    <= s8_a_r;
      s9_side_r.h    <= s8_h_r;
      s9_side_r.miss <= s8_miss_r || neg9;
      s9_side_r.sat  <= 1'b0;
      s9_disc_r      <= disc9;
    end
  end

  // square root chain, most significant root bit first
  logic                   sq_v    [ROOT_W+1];
  rci_side_t              sq_side [ROOT_W+1];
  logic [DISC_W-1:0]      sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]      sq_root [ROOT_W+1];

  assign sq_v[0]    = s9_v_r;
  assign sq_side[0] = s9_side_r;
  assign sq_rem[0]  = s9_disc_r;
  assign sq_root[0] = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    rci_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   ('{valid: sq_v[g], en: en}),
      .bit_idx (IDX_W'(ROOT_W - 1 - g)),
      .side_i  (sq_side[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .valid_o (sq_v[g+1]),
      .side_o  (sq_side[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1])
    );
  end

  // nearest forward root numerator, saturation test against A * 2^8
  rci_side_t            sv;
  logic signed [N_W-1:0] hs;
  logic signed [N_W:0]   rt, n1, n2, nsel;
  logic                 back;
  logic        [N_W-1:0] nmag;
  rci_side_t            sn_side_nxt;
  logic                 sn_v_r;
  rci_side_t            sn_side_r;
  logic [REM_W-1:0]     sn_rem_r;

  always_comb begin
    sv   = sq_side[ROOT_W];
    hs   = N_W'(signed'(sv.h)) <<< 7;
    rt   = $signed({2'b0, sq_root[ROOT_W]});
    n1   = -(N_W+1)'(hs) - rt;
    n2   = -(N_W+1)'(hs) + rt;
    nsel = n1[N_W] ? n2 : n1;
    back = n1[N_W] && n2[N_W];
    nmag = nsel[N_W-1:0];
    sn_side_nxt      = sv;
    sn_side_nxt.miss = sv.miss || back;
    sn_side_nxt.sat  = nmag >= N_W'({sv.a, 8'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_v_r <= 1'b0;
    end else if (en) begin
      sn_v_r <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_side_r <= sn_side_nxt;
      sn_rem_r  <= REM_W'({nmag, 23'b0});
    end
  end

  // divider chain, one bit of t per cell
  logic              dv_v    [T_W+1];
  rci_side_t         dv_side [T_W+1];
  logic [REM_W-1:0]  dv_rem  [T_W+1];
  logic [T_W-1:0]    dv_q    [T_W+1];

  assign dv_v[0]    = sn_v_r;
  assign dv_side[0] = sn_side_r;
  assign dv_rem[0]  = sn_rem_r;
  assign dv_q[0]    = '0;

  for (genvar g = 0; g < T_W; g++) begin : g_div
    rci_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   ('{valid: dv_v[g], en: en}),
      .bit_idx (IDX_W'(T_W - 1 - g)),
      .side_i  (dv_side[g]),
      .rem_i   (dv_rem[g]),
      .q_i     (dv_q[g]),
      .valid_o (dv_v[g+1]),
      .side_o  (dv_side[g+1]),
      .rem_o   (dv_rem[g+1]),
      .q_o     (dv_q[g+1])
    );
  end

  // t and t * dir
  rci_side_t          dside;
  logic [T_W-1:0]     tq;
  logic signed [63:0] tp_f [3];
  logic               sp1_v_r, sp1_miss_r;
  logic [T_W-1:0]     sp1_t_r;
  logic signed [31:0] sp1_o_r [3];
  logic signed [33:0] sp1_tp_r [3];

  always_comb begin
    dside = dv_side[T_W];
    tq    = dside.sat ? T_MAX : dv_q[T_W];
    for (int i = 0; i < 3; i++) begin
      tp_f[i] = $signed({1'b0, tq}) * $signed(dside.d[i]);
    end
  end

  // hit point, saturated, miss forces zeros
  logic signed [34:0] px [3];
  rci_res_t           res;
  localparam logic signed [34:0] P_MAX = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] P_MIN = -35'sh0_8000_0000;
  logic               sp2_v_r;
  rci_res_t           sp2_res_r;

  always_comb begin
    res.hit      = !sp1_miss_r;
    res.distance = sp1_miss_r ? '0 : sp1_t_r;
    for (int i = 0; i < 3; i++) begin
      px[i] = 35'(sp1_o_r[i]) + 35'(sp1_tp_r[i]);
      res.point[i] = sp1_miss_r ? '0
                   : ((px[i] > P_MAX) ? 32'(P_MAX)
                   : ((px[i] < P_MIN) ? 32'(P_MIN) : 32'(px[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp1_v_r <= 1'b0;
      sp2_v_r <= 1'b0;
    end else if (en) begin
      sp1_v_r <= dv_v[T_W];
      sp2_v_r <= sp1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp1_miss_r <= dside.miss;
      sp1_t_r    <= tq;
      for (int i = 0; i < 3; i++) begin
        sp1_o_r[i]  <= dside.o[i];
        sp1_tp_r[i] <= tp_f[i][63:30];
      end
      sp2_res_r <= res;
    end
  end

  // output register plus one skid entry; ready upstream comes from the skid flag only
  logic     out_v_r;
  rci_res_t out_r, skid_r;
  logic     pop, push;

  assign pop  = out_v_r && out_ch.ready;
  assign push = en && sp2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_r   <= sp2_res_r;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= sp2_res_r;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.hit      = out_r.hit;
  assign out_ch.distance = out_r.distance;
  assign out_ch.point_x  = out_r.point[0];
  assign out_ch.point_y  = out_r.point[1];
  assign out_ch.point_z  = out_r.point[2];

`ifndef SYNTHESIS
  // the skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while output is empty");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |->
      (out_ch.distance == '0 && out_ch.point_x == '0 && out_ch.point_y == '0
       && out_ch.point_z == '0))
    else $error("miss item with non-zero fields");

  // a stalled output with a full skid entry holds the whole chain
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ch.ready) |=> (skid_v_r && $stable(skid_r)))
    else $error("skid entry lost while stalled");
`endif

endmodule

[dv/tb_ray_cylinder_intersect.sv]
// self-checking testbench for the ray against infinite cylinder intersection block
`timescale 1ns / 1ps
module tb_ray_cylinder_intersect;
  import rci_pkg::*;

  localparam int LATENCY = 87;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rci_ray_if ray_ch ();
  rci_hit_if hit_ch ();
  rci_cfg_if cfg_ch ();

  ray_cylinder_intersect u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (ray_ch.sink),
    .out_ch (hit_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // cylinder register copy used by the predictor
  logic signed [31:0] cyl_ctr [3];
  logic signed [31:0] cyl_unit [3];
  logic [30:0]        cyl_rad;

  hit_rec_t hits_due [$];
  int       n_errors = 0;
  int       n_rays = 0;
  int       n_hits = 0;
  int       n_results = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // floor shift of a signed value
  function automatic logic signed [127:0] fshr(logic signed [127:0] x, int s);
    return x >>> s;
  endfunction

  function automatic logic signed [127:0] clip(logic signed [127:0] x,
                                               logic signed [127:0] lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic [127:0] int_sqrt(logic [127:0] x);
    logic [127:0] root;
    logic [127:0] c;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      c = root | (128'd1 << i);
      if (c * c <= x) root = c;
    end
    return root;
  endfunction

  // works out the result item for one ray against the current cylinder
  function automatic hit_rec_t predict_hit(logic signed [31:0] org [3],
                                           logic signed [31:0] dir [3]);
    hit_rec_t r;
    logic signed [127:0] da, wa, h, c, a, wsq, rr, hs, n, p;
    logic signed [127:0] w [3];
    logic signed [127:0] dp [3];
    logic signed [127:0] wp [3];
    logic signed [127:0] disc;
    logic [127:0] s, q, t;
    r = '0;
    da = 0; wa = 0; a = 0; h = 0; wsq = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = 128'(org[i]) - 128'(cyl_ctr[i]);
      da += fshr(128'(dir[i]) * 128'(cyl_unit[i]), 30);
      wa += fshr(w[i] * 128'(cyl_unit[i]), 30);
    end
    da = clip(da, (128'sd1 <<< 32) - 1);
    wa = clip(wa, (128'sd1 <<< 32) - 1);
    for (int i = 0; i < 3; i++) begin
      dp[i] = clip(128'(dir[i]) - fshr(da * 128'(cyl_unit[i]), 30), (128'sd1 <<< 31) - 1);
      wp[i] = clip(w[i] - fshr(wa * 128'(cyl_unit[i]), 30), (128'sd1 <<< 32) - 1);
      a += fshr(dp[i] * dp[i], 30);
      h += fshr(dp[i] * wp[i], 30);
      wsq += fshr(wp[i] * wp[i], 16);
    end
    rr = fshr(128'($signed({1'b0, cyl_rad})) * 128'($signed({1'b0, cyl_rad})), 16);
    c = wsq - rr;
    // degenerate perpendicular direction
    if (a < 11) return r;
    // discriminant in Q.46
    disc = ((h * h) <<< 14) - ((a * c) <<< 0);
    if (disc < 0) return r;
    s = int_sqrt(disc);
    hs = h <<< 7;
    n = -hs - $signed(s);
    if (n < 0) begin
      n = -hs + $signed(s);
      if (n < 0) return r;
    end
    q = (128'(n) << 23) / 128'(a);
    t = (q > 128'h7fff_ffff) ? 128'h7fff_ffff : q;
    r.hit = 1'b1;
    r.distance = t[30:0];
    for (int i = 0; i < 3; i++) begin
      p = 128'(org[i]) + fshr($signed(t) * 128'(dir[i]), 30);
      if (p > 128'sh7fff_ffff) p = 128'sh7fff_ffff;
      if (p < -128'sh8000_0000) p = -128'sh8000_0000;
      if (i == 0) r.px = p[31:0];
      else if (i == 1) r.py = p[31:0];
      else r.pz = p[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("mismatch %s at result %0d: got %h expected %h", what, n_results, got, want);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CENTER_X: cyl_ctr[0] = val;
      REG_CENTER_Y: cyl_ctr[1] = val;
      REG_CENTER_Z: cyl_ctr[2] = val;
      REG_AXIS_X:   cyl_unit[0] = val;
      REG_AXIS_Y:   cyl_unit[1] = val;
      REG_AXIS_Z:   cyl_unit[2] = val;
      REG_RADIUS:   cyl_rad = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_cylinder(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                              logic [31:0] rad);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_AXIS_X, ux);
    write_reg(REG_AXIS_Y, uy);
    write_reg(REG_AXIS_Z, uz);
    write_reg(REG_RADIUS, rad);
    cfg_ch.valid <= 1'b0;
  endtask

  // sends one ray, with random idle cycles ahead of it
  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    while ($urandom_range(99) < send_idle_pct) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid    <= 1'b1;
    ray_ch.origin_x <= ox;
    ray_ch.origin_y <= oy;
    ray_ch.origin_z <= oz;
    ray_ch.dir_x    <= dx;
    ray_ch.dir_y    <= dy;
    ray_ch.dir_z    <= dz;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    org[0] = ox; org[1] = oy; org[2] = oz;
    dir[0] = dx; dir[1] = dy; dir[2] = dz;
    hits_due.insert(hits_due.size(), predict_hit(org, dir));
    n_rays++;
  endtask

  task automatic go_idle();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_q16(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // unit-ish direction with random jitter
  function automatic logic [31:0] rnd_dir();
    return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  // random content: mostly near the cylinder so hits are common, some full-range noise
  task automatic rand_ray();
    if ($urandom_range(9) < 8)
      send_ray(rnd_q16(32'h0004_0000), rnd_q16(32'h0004_0000), rnd_q16(32'h0004_0000),
               rnd_dir(), rnd_dir(), rnd_dir());
    else
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed();
    set_cylinder(0, 0, 0, 0, 0, 32'h4000_0000, 32'h0001_0000);
    // ray from outside straight through
    send_ray(32'hfffd_0000, 0, 0, 32'h4000_0000, 0, 0);
    // origin inside, one root behind
    send_ray(0, 0, 0, 0, 32'h4000_0000, 0);
    // both roots behind
    send_ray(32'h0003_0000, 0, 0, 32'h4000_0000, 0, 0);
    // passes wide of the cylinder, negative discriminant
    send_ray(32'hfffd_0000, 32'h0005_0000, 0, 32'h4000_0000, 0, 0);
    // degenerate direction along the axis
    send_ray(0, 0, 0, 0, 0, 32'h4000_0000);
    send_ray(0, 0, 0, 0, 0, 0);
    // tangent ray
    send_ray(32'hfffd_0000, 32'h0001_0000, 0, 32'h4000_0000, 0, 0);
    // field extremes
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // tiny direction, far hit saturates distance
    send_ray(32'hfffd_0000, 0, 0, 32'd16, 0, 0);
    go_idle();
    // extreme cylinder: corner centre, non-unit axis, largest radius
    set_cylinder(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(0, 0, 0, 32'h4000_0000, 0, 0);
    send_ray(32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h4000_0000, 32'hc000_0000);
    go_idle();
    // zero radius, zero axis
    set_cylinder(0, 0, 0, 0, 0, 0, 0);
    send_ray(32'hfffd_0000, 0, 0, 32'h4000_0000, 0, 0);
    send_ray(32'h0001_0000, 32'h0001_0000, 0, 32'hd000_0000, 32'hd000_0000, 0);
    go_idle();
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) rand_ray();
    go_idle();
  endtask

  task automatic test_cylinders();
    // four random but sane cylinders, only the first with an axis-aligned unit axis
    for (int k = 0; k < 4; k++) begin
      set_cylinder(rnd_q16(32'h0002_0000), rnd_q16(32'h0002_0000), rnd_q16(32'h0002_0000),
                   (k == 0) ? 32'h4000_0000 : rnd_dir(), (k == 1) ? 32'h4000_0000 : 0,
                   (k >= 2) ? 32'h2d41_3ccd : 0, $urandom_range(32'h0003_0000));
      test_random(150, 0, 0);
    end
  endtask

  // result checker, with random back-pressure
  always @(posedge clk) begin
    hit_rec_t want;
    if (rst_n && hit_ch.valid && hit_ch.ready) begin
      if (hits_due.size() == 0) begin
        report_mismatch("unexpected item", {63'd0, hit_ch.hit}, 64'd0);
      end else begin
        want = hits_due.pop_front();
        if (hit_ch.hit !== want.hit) report_mismatch("hit", hit_ch.hit, want.hit);
        if (hit_ch.distance !== want.distance)
          report_mismatch("distance", hit_ch.distance, want.distance);
        if (hit_ch.point_x !== want.px) report_mismatch("point_x", hit_ch.point_x, want.px);
        if (hit_ch.point_y !== want.py) report_mismatch("point_y", hit_ch.point_y, want.py);
        if (hit_ch.point_z !== want.pz) report_mismatch("point_z", hit_ch.point_z, want.pz);
        if (want.hit) n_hits++;
      end
      n_results++;
    end
    hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CENTER_X;
    cfg_ch.data = '0;
    cyl_ctr[0] = 0; cyl_ctr[1] = 0; cyl_ctr[2] = 0;
    cyl_unit[0] = 0; cyl_unit[1] = 0; cyl_unit[2] = 32'h4000_0000;
    cyl_rad = 31'h0001_0000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cylinders();
    set_cylinder(0, 0, 0, 0, 32'h4000_0000, 0, 32'h0002_0000);
    test_random(250, 77, 0);
    test_random(250, 0, 77);
    test_random(250, 20, 20);
    test_random(250, 0, 0);
    $display("covered %0d rays, %0d results, %0d hits, across eight cylinder settings",
             n_rays, n_results, n_hits);
    if (n_errors == 0) $display("tb_ray_cylinder_intersect: done, clean");
    else $display("tb_ray_cylinder_intersect: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb_ray_cylinder_intersect: done, errors");
    $finish;
  end

endmodule
